// File: rtl/fusr_pkg.sv
// Shared types and constants of the firmware update stream receiver.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package fusr_pkg;

   localparam int MAX_BLOCK       = 16;
   localparam int START_BYTES     = 4;
   localparam int PAGE_INDEX_BITS = 16;
   localparam int META_BYTES      = 12;
   localparam int END_BYTES       = 4;

   localparam int BLK_IDX_BITS = $clog2(MAX_BLOCK);
   localparam int BLK_CNT_BITS = $clog2(MAX_BLOCK + 1);
   localparam int MATCH_BITS   = 4;

   localparam int TDATA_BITS = 48;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 64;

   localparam logic [CSR_AW-1:0] REG_START_MAGIC = 3'd0;
   localparam logic [CSR_AW-1:0] REG_END_MAGIC   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_EXP_VERSION = 3'd2;
   localparam logic [CSR_AW-1:0] REG_EXP_TARGET  = 3'd3;
   localparam logic [CSR_AW-1:0] REG_BLOCK_SIZE  = 3'd4;
   localparam logic [CSR_AW-1:0] REG_PAGE_SIZE   = 3'd5;
   localparam logic [CSR_AW-1:0] REG_ERASED_FILL = 3'd6;

   typedef enum logic [2:0] {
      KIND_STATUS = 3'd0,
      KIND_ERASE  = 3'd1,
      KIND_WRITE  = 3'd2,
      KIND_START  = 3'd3,
      KIND_APPLY  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_VERSION   = 3'd1,
      ERR_TARGET    = 3'd2,
      ERR_BLOCK     = 3'd3,
      ERR_PAGE      = 3'd4,
      ERR_OVERFLOW  = 3'd5,
      ERR_END_MAGIC = 3'd6
   } err_type;

   typedef enum logic [1:0] {
      ST_START   = 2'd0,
      ST_META    = 2'd1,
      ST_PAYLOAD = 2'd2,
      ST_END     = 2'd3
   } stage_type;

   typedef enum logic [1:0] {
      OUT_PRE  = 2'd0,
      OUT_WR   = 2'd1,
      OUT_STAT = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic                    load_byte;
      logic                    rem_start;
      logic                    eval;
      logic                    out_load;
      out_sel_type             out_sel;
      logic [BLK_IDX_BITS-1:0] wr_idx;
   } cmd_type;

   typedef struct packed {
      logic                    need_rem;
      logic                    rem_hit;
      logic                    rem_busy;
      logic                    has_pre;
      logic [BLK_CNT_BITS-1:0] wr_count;
      logic                    out_free;
   } sts_type;

endpackage

// File: rtl/fusr_rem.sv
// Restoring remainder unit: page size modulo block size, one bit per cycle.
// Depends on fusr_pkg for the divisor width.
`timescale 1ns / 1ps

module fusr_rem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [15:0]                       dividend,
   input  logic [fusr_pkg::BLK_CNT_BITS-1:0] divisor,
   output logic                              busy,
   output logic [fusr_pkg::BLK_CNT_BITS-1:0] rem
);

   logic                              busy_ff;
   logic [3:0]                        cnt_ff;
   logic [15:0]                       dvd_ff;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] div_ff;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] rem_ff;
   logic [fusr_pkg::BLK_CNT_BITS:0]   trial;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] rem_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[15]};
      if (trial >= {1'b0, div_ff}) begin
         trial = trial - {1'b0, div_ff};
      end
      rem_in = trial[fusr_pkg::BLK_CNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 4'd15;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[14:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;

endmodule

// File: rtl/fusr_dp.sv
// Datapath: configuration registers, session state, block buffer, output register.
// Depends on fusr_pkg and fusr_rem; driven by fusr_ctrl through cmd_type.
`timescale 1ns / 1ps

module fusr_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  fusr_pkg::cmd_type              cmd,
   output fusr_pkg::sts_type              sts,
   input  logic [7:0]                     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fusr_pkg::TDATA_BITS-1:0] rsp_tdata,
   output logic [2:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [fusr_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [fusr_pkg::CSR_DW-1:0]    csr_wdata
);

   typedef enum logic [1:0] {RES_MORE, RES_DONE, RES_BAD} res_type;

   typedef struct packed {
      res_type                         res;
      logic [fusr_pkg::MATCH_BITS-1:0] cnt;
   } match_type;

   typedef struct packed {
      fusr_pkg::stage_type                  stage;
      logic [fusr_pkg::MATCH_BITS-1:0]      smc;
      logic [3:0]                           sbc;
      logic [31:0]                          ver;
      logic [31:0]                          tid;
      logic [31:0]                          psz;
      logic [31:0]                          pcnt;
      logic [fusr_pkg::PAGE_INDEX_BITS-1:0] pidx;
      logic [15:0]                          pfill;
      logic [7:0]                           bsl;
      logic                                 dirty;
      logic [15:0]                          boff;
      logic [fusr_pkg::BLK_CNT_BITS-1:0]    bfill;
   } sess_type;

   function automatic match_type start_fn(input logic [fusr_pkg::MATCH_BITS-1:0] cnt,
                                          input logic [7:0] b,
                                          input logic [63:0] magic);
      match_type                       m;
      logic [fusr_pkg::MATCH_BITS-1:0] nxt;
      nxt = cnt + 1'b1;
      if (magic[{cnt[2:0], 3'b000} +: 8] != b) begin
         m.res = RES_BAD;
         m.cnt = '0;
      end else if (nxt >= fusr_pkg::MATCH_BITS'(fusr_pkg::START_BYTES)) begin
         m.res = RES_DONE;
         m.cnt = '0;
      end else begin
         m.res = RES_MORE;
         m.cnt = nxt;
      end
      return m;
   endfunction

   // configuration
   logic [63:0] start_magic_ff;
   logic [31:0] end_magic_ff;
   logic [31:0] exp_ver_ff;
   logic [31:0] exp_tid_ff;
   logic [7:0]  bss_ff;
   logic [15:0] pss_ff;
   logic [7:0]  fill_ff;

   // session
   sess_type    sess_ff, sess_in;
   logic        failed_ff, failed_in;
   logic        completed_ff, completed_in;
   logic [7:0]  byte_ff;
   logic [7:0]  buf_ff [fusr_pkg::MAX_BLOCK];
   logic        buf_we;
   logic [fusr_pkg::BLK_IDX_BITS-1:0] buf_idx;

   // plan of the current item's results
   logic                              plan_pre_ff, plan_pre_in;
   fusr_pkg::kind_type                plan_kind_ff, plan_kind_in;
   logic [15:0]                       plan_page_ff;
   logic [15:0]                       plan_off_ff, plan_off_in;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] plan_fill_ff, plan_fill_in;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] plan_wcnt_ff, plan_wcnt_in;
   fusr_pkg::err_type                 plan_err_ff, plan_err_in;

   // remainder cache
   logic                              cache_ok_ff;
   logic                              cache_zero_ff;
   logic                              rem_pend_ff;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] cache_div_ff;
   logic [7:0]                        div_sel;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] div5;
   logic                              rem_busy;
   logic [fusr_pkg::BLK_CNT_BITS-1:0] rem_val;

   // output register
   logic                 out_valid_ff;
   fusr_pkg::kind_type   out_kind_ff;
   logic [15:0]          out_page_ff;
   logic [15:0]          out_off_ff;
   logic [7:0]           out_data_ff;
   logic                 out_last_ff;
   fusr_pkg::err_type    out_err_ff;
   logic                 out_failed_ff;
   logic                 out_completed_ff;
   logic                 out_free;

   assign div_sel = (sess_ff.stage == fusr_pkg::ST_META) ? bss_ff : sess_ff.bsl;
   assign div5    = div_sel[fusr_pkg::BLK_CNT_BITS-1:0];

   fusr_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.rem_start),
      .dividend (pss_ff),
      .divisor  (div5),
      .busy     (rem_busy),
      .rem      (rem_val)
   );

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      sts.need_rem = (div_sel != 8'd0) && (div_sel <= 8'(fusr_pkg::MAX_BLOCK)) &&
                     (pss_ff != 16'd0) &&
                     (((sess_ff.stage == fusr_pkg::ST_META) &&
                       (sess_ff.sbc == 4'(fusr_pkg::META_BYTES - 1))) ||
                      (sess_ff.stage == fusr_pkg::ST_PAYLOAD));
      sts.rem_hit  = cache_ok_ff && (cache_div_ff == div5);
      sts.rem_busy = rem_busy;
      sts.has_pre  = plan_pre_ff;
      sts.wr_count = plan_wcnt_ff;
      sts.out_free = out_free;
   end

   // one item step
   always_comb begin
      sess_type  s;
      match_type m1;
      match_type m2;
      res_type   r;
      logic      pdone;
      logic      flush;

      s            = sess_ff;
      failed_in    = failed_ff;
      completed_in = completed_ff;
      plan_pre_in  = 1'b0;
      plan_kind_in = fusr_pkg::KIND_STATUS;
      plan_off_in  = '0;
      plan_fill_in = '0;
      plan_wcnt_in = '0;
      plan_err_in  = fusr_pkg::ERR_NONE;
      buf_we       = 1'b0;
      buf_idx      = '0;
      r            = RES_MORE;
      pdone        = 1'b0;
      flush        = 1'b0;
      m1           = start_fn(sess_ff.smc, byte_ff, start_magic_ff);
      m2           = start_fn('0, byte_ff, start_magic_ff);

      if (failed_ff) begin
         s.smc = m1.cnt;
         if (m1.res == RES_DONE) begin
            s            = '0;
            failed_in    = 1'b0;
            completed_in = 1'b0;
            s.stage      = fusr_pkg::ST_META;
         end
      end else if (sess_ff.stage != fusr_pkg::ST_START && m1.res == RES_DONE) begin
         s            = '0;
         completed_in = 1'b0;
         s.stage      = fusr_pkg::ST_META;
      end else begin
         s.smc = m1.cnt;
         case (sess_ff.stage)
            fusr_pkg::ST_START: begin
               r = m1.res;
            end
            fusr_pkg::ST_META: begin
               if (s.sbc < 4'd4) begin
                  s.ver[{s.sbc[1:0], 3'b000} +: 8] = s.ver[{s.sbc[1:0], 3'b000} +: 8] | byte_ff;
               end else if (s.sbc < 4'd8) begin
                  s.tid[{s.sbc[1:0], 3'b000} +: 8] = s.tid[{s.sbc[1:0], 3'b000} +: 8] | byte_ff;
               end else begin
                  s.psz[{s.sbc[1:0], 3'b000} +: 8] = s.psz[{s.sbc[1:0], 3'b000} +: 8] | byte_ff;
               end
               s.sbc = s.sbc + 4'd1;
               if (s.sbc != 4'(fusr_pkg::META_BYTES)) begin
                  r = RES_MORE;
               end else if (s.ver != exp_ver_ff) begin
                  plan_err_in = fusr_pkg::ERR_VERSION;
                  r           = RES_BAD;
               end else if (s.tid != exp_tid_ff) begin
                  plan_err_in = fusr_pkg::ERR_TARGET;
                  r           = RES_BAD;
               end else begin
                  plan_pre_in  = 1'b1;
                  plan_kind_in = fusr_pkg::KIND_START;
                  s.bsl        = bss_ff;
                  if (bss_ff == 8'd0 || bss_ff > 8'(fusr_pkg::MAX_BLOCK)) begin
                     plan_err_in = fusr_pkg::ERR_BLOCK;
                     failed_in   = 1'b1;
                     s           = '0;
                     r           = RES_BAD;
                  end else if (pss_ff == 16'd0 || !cache_zero_ff) begin
                     plan_err_in = fusr_pkg::ERR_PAGE;
                     failed_in   = 1'b1;
                     s           = '0;
                     r           = RES_BAD;
                  end else begin
                     r = RES_DONE;
                  end
               end
            end
            fusr_pkg::ST_PAYLOAD: begin
               if (s.bsl == 8'd0 || s.bsl > 8'(fusr_pkg::MAX_BLOCK) ||
                   pss_ff == 16'd0 || !cache_zero_ff) begin
                  plan_err_in = fusr_pkg::ERR_PAGE;
                  failed_in   = 1'b1;
                  s           = '0;
                  r           = RES_BAD;
               end else if (s.pfill >= pss_ff) begin
                  plan_err_in = fusr_pkg::ERR_OVERFLOW;
                  failed_in   = 1'b1;
                  s           = '0;
                  r           = RES_BAD;
               end else begin
                  if (s.pfill == 16'd0 && !s.dirty) begin
                     plan_pre_in  = 1'b1;
                     plan_kind_in = fusr_pkg::KIND_ERASE;
                  end
                  if (!s.dirty) begin
                     s.boff  = s.pfill;
                     s.bfill = '0;
                     s.dirty = 1'b1;
                  end
                  buf_we  = 1'b1;
                  buf_idx = s.bfill[fusr_pkg::BLK_IDX_BITS-1:0];
                  s.bfill = s.bfill + 1'b1;
                  s.pfill = s.pfill + 16'd1;
                  s.pcnt  = s.pcnt + 32'd1;
                  flush   = (8'(s.bfill) == s.bsl) || (s.pfill == pss_ff) ||
                            (s.pcnt == s.psz);
                  if (flush) begin
                     plan_off_in  = s.boff;
                     plan_fill_in = s.bfill;
                     plan_wcnt_in = s.bsl[fusr_pkg::BLK_CNT_BITS-1:0];
                     s.dirty      = 1'b0;
                     s.boff       = '0;
                     s.bfill      = '0;
                  end
                  pdone = (s.pfill == pss_ff);
                  if (pdone) begin
                     s.pfill = '0;
                  end
                  if (s.pcnt == s.psz) begin
                     s.pfill = '0;
                     s.sbc   = '0;
                     r       = RES_DONE;
                  end else begin
                     r = RES_MORE;
                     if (pdone) begin
                        s.pidx = s.pidx + 1'b1;
                     end
                  end
               end
            end
            default: begin
               if (end_magic_ff[{s.sbc[1:0], 3'b000} +: 8] != byte_ff) begin
                  plan_err_in = fusr_pkg::ERR_END_MAGIC;
                  s.sbc       = '0;
                  r           = RES_BAD;
               end else begin
                  s.sbc = s.sbc + 4'd1;
                  if (s.sbc >= 4'(fusr_pkg::END_BYTES)) begin
                     s.sbc = '0;
                     r     = RES_DONE;
                  end else begin
                     r = RES_MORE;
                  end
               end
            end
         endcase

         if (r == RES_DONE) begin
            case (sess_ff.stage)
               fusr_pkg::ST_END: begin
                  completed_in = 1'b1;
                  plan_pre_in  = 1'b1;
                  plan_kind_in = fusr_pkg::KIND_APPLY;
                  s            = '0;
               end
               fusr_pkg::ST_META: begin
                  s.sbc   = '0;
                  s.stage = fusr_pkg::ST_PAYLOAD;
               end
               fusr_pkg::ST_PAYLOAD: begin
                  s.sbc   = '0;
                  s.stage = fusr_pkg::ST_END;
               end
               default: begin
                  s.sbc   = '0;
                  s.stage = fusr_pkg::ST_META;
               end
            endcase
         end else if (r == RES_BAD && !failed_in) begin
            // retry the byte as the first start magic byte
            s     = '0;
            s.smc = m2.cnt;
            if (m2.res == RES_BAD) begin
               completed_in = 1'b0;
            end
         end
      end

      if (!cmd.eval) begin
         s            = sess_ff;
         failed_in    = failed_ff;
         completed_in = completed_ff;
         buf_we       = 1'b0;
      end
      sess_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_magic_ff <= '0;
         end_magic_ff   <= '0;
         exp_ver_ff     <= '0;
         exp_tid_ff     <= '0;
         bss_ff         <= 8'd8;
         pss_ff         <= 16'd2048;
         fill_ff        <= 8'hFF;
      end else if (csr_we) begin
         case (csr_addr)
            fusr_pkg::REG_START_MAGIC: start_magic_ff <= csr_wdata;
            fusr_pkg::REG_END_MAGIC:   end_magic_ff   <= csr_wdata[31:0];
            fusr_pkg::REG_EXP_VERSION: exp_ver_ff     <= csr_wdata[31:0];
            fusr_pkg::REG_EXP_TARGET:  exp_tid_ff     <= csr_wdata[31:0];
            fusr_pkg::REG_BLOCK_SIZE:  bss_ff         <= csr_wdata[7:0];
            fusr_pkg::REG_PAGE_SIZE:   pss_ff         <= csr_wdata[15:0];
            fusr_pkg::REG_ERASED_FILL: fill_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sess_ff      <= '0;
         failed_ff    <= 1'b0;
         completed_ff <= 1'b0;
         plan_pre_ff  <= 1'b0;
         plan_wcnt_ff <= '0;
         cache_ok_ff  <= 1'b0;
         rem_pend_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sess_ff      <= sess_in;
         failed_ff    <= failed_in;
         completed_ff <= completed_in;
         if (cmd.eval) begin
            plan_pre_ff  <= plan_pre_in;
            plan_wcnt_ff <= plan_wcnt_in;
         end
         if (csr_we && csr_addr == fusr_pkg::REG_PAGE_SIZE) begin
            cache_ok_ff <= 1'b0;
         end else if (rem_pend_ff && !rem_busy) begin
            cache_ok_ff <= 1'b1;
         end
         if (cmd.rem_start) begin
            rem_pend_ff <= 1'b1;
         end else if (!rem_busy) begin
            rem_pend_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         byte_ff <= req_tdata;
      end
      if (buf_we) begin
         buf_ff[buf_idx] <= byte_ff;
      end
      if (cmd.rem_start) begin
         cache_div_ff <= div5;
      end
      if (rem_pend_ff && !rem_busy) begin
         cache_zero_ff <= (rem_val == '0);
      end
      if (cmd.eval) begin
         plan_kind_ff <= plan_kind_in;
         plan_page_ff <= 16'(sess_ff.pidx);
         plan_off_ff  <= plan_off_in;
         plan_fill_ff <= plan_fill_in;
         plan_err_ff  <= plan_err_in;
      end
      if (cmd.out_load) begin
         out_failed_ff    <= failed_ff;
         out_completed_ff <= completed_ff;
         out_off_ff       <= '0;
         out_data_ff      <= '0;
         out_last_ff      <= 1'b0;
         out_err_ff       <= fusr_pkg::ERR_NONE;
         case (cmd.out_sel)
            fusr_pkg::OUT_PRE: begin
               out_kind_ff <= plan_kind_ff;
               out_page_ff <= (plan_kind_ff == fusr_pkg::KIND_ERASE) ? plan_page_ff : 16'd0;
            end
            fusr_pkg::OUT_WR: begin
               out_kind_ff <= fusr_pkg::KIND_WRITE;
               out_page_ff <= plan_page_ff;
               out_off_ff  <= plan_off_ff + 16'(cmd.wr_idx);
               out_data_ff <= ({1'b0, cmd.wr_idx} < plan_fill_ff) ? buf_ff[cmd.wr_idx]
                                                                   : fill_ff;
            end
            default: begin
               out_kind_ff <= fusr_pkg::KIND_STATUS;
               out_page_ff <= '0;
               out_last_ff <= 1'b1;
               out_err_ff  <= plan_err_ff;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'b000, out_completed_ff, out_failed_ff, out_err_ff,
                        out_data_ff, out_off_ff, out_page_ff};

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> out_kind_ff == fusr_pkg::KIND_STATUS)
      else $error("last item is not a status item");

   a_failed_idle: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> sess_ff.stage == fusr_pkg::ST_START)
      else $error("failure flag set outside the start stage");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      sess_ff.bfill <= fusr_pkg::BLK_CNT_BITS'(fusr_pkg::MAX_BLOCK))
      else $error("block fill beyond the buffer");

endmodule

// File: rtl/fusr_ctrl.sv
// Controller: sequences accept, remainder check, step and result emission.
// Depends on fusr_pkg; commands fusr_dp through cmd_type.
`timescale 1ns / 1ps

module fusr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  fusr_pkg::sts_type sts,
   output fusr_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {S_IDLE, S_DIVW, S_EVAL, S_PRE, S_WR, S_STAT} state_type;

   state_type                         state_ff, state_in;
   logic [fusr_pkg::BLK_IDX_BITS-1:0] wr_idx_ff, wr_idx_in;

   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      cmd.load_byte = 1'b0;
      cmd.rem_start = 1'b0;
      cmd.eval      = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.out_sel   = fusr_pkg::OUT_STAT;
      cmd.wr_idx    = wr_idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_byte = 1'b1;
               if (sts.need_rem && !sts.rem_hit) begin
                  cmd.rem_start = 1'b1;
                  state_in      = S_DIVW;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_DIVW: begin
            if (!sts.rem_busy) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_PRE;
         end
         S_PRE: begin
            if (!sts.has_pre) begin
               state_in = (sts.wr_count != '0) ? S_WR : S_STAT;
            end else if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = fusr_pkg::OUT_PRE;
               state_in     = (sts.wr_count != '0) ? S_WR : S_STAT;
            end
         end
         S_WR: begin
            cmd.out_sel = fusr_pkg::OUT_WR;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if ({1'b0, wr_idx_ff} + 1'b1 == sts.wr_count) begin
                  wr_idx_in = '0;
                  state_in  = S_STAT;
               end else begin
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
            end
         end
         S_STAT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wr_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         wr_idx_ff <= wr_idx_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   a_wr_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR |-> sts.wr_count != '0)
      else $error("write phase with nothing to write");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register overwritten");

   a_eval_cached: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL && sts.need_rem |-> sts.rem_hit)
      else $error("step evaluated without a page size check");

endmodule

// File: rtl/firmware_update_stream_receiver.sv
// Top level of the firmware update stream receiver.
// Depends on fusr_pkg, fusr_ctrl and fusr_dp.
//
// Takes one stream byte at a time and answers each with a run of items that
// ends in a status item marked by rsp_tlast: an optional update start, page
// erase or apply item, then up to MAX_BLOCK write items when a block is
// flushed, then the status. A byte passes through accept, step, leading item
// slot, the write items and status; the items leave one per cycle while
// rsp_tready is high, through a single output register, and a start, erase
// or apply item goes out in the leading item slot at no extra cost. A page
// size check against a block size other than the last one checked since the
// last page size change (on the last metadata byte or a payload byte) adds a
// wait for the bit-serial remainder, which is then cached.
`timescale 1ns / 1ps

module firmware_update_stream_receiver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // byte_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // page[15:0], offset[31:16], data[39:32], error_code[42:40],
   // failed[43], completed[44], zero[47:45]
   output logic [fusr_pkg::TDATA_BITS-1:0] rsp_tdata,
   output logic [2:0]                      rsp_tuser,  // kind
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [fusr_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [fusr_pkg::CSR_DW-1:0]     csr_wdata
);

   fusr_pkg::cmd_type cmd;
   fusr_pkg::sts_type sts;

   fusr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fusr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule
